// File: hdl/snfcs_pkg.sv
// Shared types and constants for the SPI NOR flash command sequencer.
`timescale 1ns / 1ps
`default_nettype none
package snfcs_pkg;

    localparam int ADDR_W            = 24;
    localparam int DEF_PAGE_BYTES    = 256;
    localparam int DEF_SECTOR_BYTES  = 4096;

    localparam logic [4:0] PH_IDLE     = 5'd0;
    localparam logic [4:0] PH_STAT_CMD = 5'd1;
    localparam logic [4:0] PH_STAT_DAT = 5'd2;
    localparam logic [4:0] PH_ID_HDR   = 5'd3;
    localparam logic [4:0] PH_ID_HI    = 5'd4;
    localparam logic [4:0] PH_ID_LO    = 5'd5;
    localparam logic [4:0] PH_BUSY_CMD = 5'd6;
    localparam logic [4:0] PH_BUSY_DAT = 5'd7;
    localparam logic [4:0] PH_WEN      = 5'd8;
    localparam logic [4:0] PH_WEL_CMD  = 5'd9;
    localparam logic [4:0] PH_WEL_DAT  = 5'd10;
    localparam logic [4:0] PH_HDR      = 5'd11;
    localparam logic [4:0] PH_DATA     = 5'd12;
    localparam logic [4:0] PH_POST_CMD = 5'd13;
    localparam logic [4:0] PH_POST_DAT = 5'd14;

    localparam logic [2:0] K_XFER = 3'd0;
    localparam logic [2:0] K_READ = 3'd1;
    localparam logic [2:0] K_STAT = 3'd2;
    localparam logic [2:0] K_ID   = 3'd3;
    localparam logic [2:0] K_DONE = 3'd4;
    localparam logic [2:0] K_REJ  = 3'd5;

    localparam logic [2:0] OP_STATUS = 3'd0;
    localparam logic [2:0] OP_ID     = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_PROG   = 3'd3;
    localparam logic [2:0] OP_SE     = 3'd4;
    localparam logic [2:0] OP_BE     = 3'd5;
    localparam logic [2:0] OP_CE     = 3'd6;
    localparam logic [2:0] OP_RANGE  = 3'd7;

    localparam logic [7:0] CMD_RDSR  = 8'h05;
    localparam logic [7:0] CMD_WREN  = 8'h06;
    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_PP    = 8'h02;
    localparam logic [7:0] CMD_BE    = 8'hD8;
    localparam logic [7:0] CMD_SE    = 8'h20;
    localparam logic [7:0] CMD_CE    = 8'hC7;
    localparam logic [7:0] CMD_RDID  = 8'h90;
    localparam logic [7:0] BYTE_DUMMY = 8'hFF;
    localparam logic [7:0] BYTE_ZERO  = 8'h00;

    localparam logic      KIND_START = 1'b0;

    typedef struct packed {
        logic        kind;
        logic [2:0]  op;
        logic [23:0] address;
        logic [23:0] length;
        logic [7:0]  rx_byte;
        logic [7:0]  wr_byte;
    } req_t;

    typedef struct packed {
        logic [2:0]  out_kind;
        logic [7:0]  tx_byte;
        logic        release_cs;
        logic [15:0] value;
        logic        last;
    } rsp_t;

endpackage
`default_nettype wire

// File: hdl/snfcs_core.sv
// Sequencer state registers and the per-request next-state and result logic.
`timescale 1ns / 1ps
`default_nettype none
module snfcs_core #(
    parameter int PAGE_BYTES   = 256,
    parameter int SECTOR_BYTES = 4096
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 go,
    input  snfcs_pkg::req_t     item,
    output snfcs_pkg::rsp_t     res0,
    output snfcs_pkg::rsp_t     res1,
    output logic [1:0]          res_cnt
);
    import snfcs_pkg::*;

    localparam int PG_LOG = $clog2(PAGE_BYTES);
    localparam int SC_LOG = $clog2(SECTOR_BYTES);
    localparam int SECT_W = ADDR_W - SC_LOG;
    localparam logic [ADDR_W-1:0] MAXSEC = ADDR_W'((32'hFFFFFF) >> SC_LOG);
    localparam logic [PG_LOG:0]   PAGE_C = (PG_LOG+1)'(PAGE_BYTES);

    logic [4:0]        phase_reg, phase_next;
    logic [2:0]        op_reg, op_next;
    logic [ADDR_W-1:0] ap_reg, ap_next;
    logic [ADDR_W-1:0] br_reg, br_next;
    logic [PG_LOG:0]   pr_reg, pr_next;
    logic [2:0]        hc_reg, hc_next;
    logic [7:0]        idh_reg, idh_next;
    logic [SECT_W-1:0] es_reg, es_next;

    logic [PG_LOG:0]   room;
    logic [ADDR_W-1:0] chunk_ap;
    logic [ADDR_W-1:0] chunk_br;
    logic [PG_LOG:0]   chunk;
    logic [ADDR_W-1:0] caddr;
    logic [ADDR_W-1:0] br_dec;
    logic [PG_LOG:0]   pr_dec;
    logic [SECT_W-1:0] es_new;
    logic [7:0]        wop;
    logic              erase;

    always_comb
    begin
        room  = PAGE_C - {1'b0, chunk_ap[PG_LOG-1:0]};
        chunk = ({{(ADDR_W-PG_LOG-1){1'b0}}, room} < chunk_br) ? room : chunk_br[PG_LOG:0];
    end

    always_comb
    begin
        caddr  = (op_reg == OP_RANGE) ? (ap_reg << SC_LOG) : ap_reg;
        br_dec = br_reg - ADDR_W'(1);
        pr_dec = pr_reg - (PG_LOG+1)'(1);
        es_new = (item.length < MAXSEC) ? item.length[SECT_W-1:0] : MAXSEC[SECT_W-1:0];
        erase  = (op_reg >= OP_SE);
        unique case (op_reg)
            OP_PROG: wop = CMD_PP;
            OP_BE:   wop = CMD_BE;
            OP_CE:   wop = CMD_CE;
            default: wop = CMD_SE;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        op_next    = op_reg;
        ap_next    = ap_reg;
        br_next    = br_reg;
        pr_next    = pr_reg;
        hc_next    = hc_reg;
        idh_next   = idh_reg;
        es_next    = es_reg;
        res0       = '0;
        res1       = '0;
        res_cnt    = 2'd0;
        chunk_ap   = ap_reg;
        chunk_br   = br_reg;

        if (item.kind == KIND_START) begin
            res_cnt = 2'd1;
            if (phase_reg != PH_IDLE) begin
                res0.out_kind = K_REJ;
            end else if ((item.op == OP_READ || item.op == OP_PROG) && item.length == '0) begin
                res0.out_kind = K_REJ;
            end else begin
                op_next = item.op;
                res0.out_kind = K_XFER;
                unique case (item.op)
                    OP_STATUS:
                    begin
                        res0.tx_byte = CMD_RDSR;
                        phase_next = PH_STAT_CMD;
                    end
                    OP_ID:
                    begin
                        hc_next = 3'd1;
                        res0.tx_byte = CMD_RDID;
                        phase_next = PH_ID_HDR;
                    end
                    OP_RANGE:
                    begin
                        es_next = es_new;
                        if (item.address > {{SC_LOG{1'b0}}, es_new}) begin
                            res0.out_kind = K_DONE;
                            phase_next = PH_IDLE;
                        end else begin
                            ap_next = item.address;
                            res0.tx_byte = CMD_RDSR;
                            phase_next = PH_BUSY_CMD;
                        end
                    end
                    default:
                    begin
                        ap_next = item.address;
                        br_next = item.length;
                        chunk_ap = item.address;
                        chunk_br = item.length;
                        if (item.op == OP_PROG)
                            pr_next = chunk;
                        res0.tx_byte = CMD_RDSR;
                        phase_next = PH_BUSY_CMD;
                    end
                endcase
            end
        end else if (phase_reg != PH_IDLE) begin
            res_cnt = 2'd1;
            res0.out_kind = K_XFER;
            unique case (phase_reg)
                PH_STAT_CMD:
                begin
                    res0.tx_byte = BYTE_DUMMY;
                    res0.release_cs = 1'b1;
                    phase_next = PH_STAT_DAT;
                end
                PH_STAT_DAT:
                begin
                    res0.out_kind = K_STAT;
                    res0.value = {8'd0, item.rx_byte};
                    res1.out_kind = K_DONE;
                    res_cnt = 2'd2;
                    phase_next = PH_IDLE;
                end
                PH_ID_HDR:
                begin
                    if (hc_reg < 3'd4) begin
                        hc_next = hc_reg + 3'd1;
                        res0.tx_byte = BYTE_ZERO;
                    end else begin
                        res0.tx_byte = BYTE_DUMMY;
                        phase_next = PH_ID_HI;
                    end
                end
                PH_ID_HI:
                begin
                    idh_next = item.rx_byte;
                    res0.tx_byte = BYTE_DUMMY;
                    res0.release_cs = 1'b1;
                    phase_next = PH_ID_LO;
                end
                PH_ID_LO:
                begin
                    res0.out_kind = K_ID;
                    res0.value = {idh_reg, item.rx_byte};
                    res1.out_kind = K_DONE;
                    res_cnt = 2'd2;
                    phase_next = PH_IDLE;
                end
                PH_BUSY_CMD, PH_WEL_CMD, PH_POST_CMD:
                begin
                    res0.tx_byte = BYTE_DUMMY;
                    res0.release_cs = 1'b1;
                    phase_next = phase_reg + 5'd1;
                end
                PH_BUSY_DAT:
                begin
                    if (item.rx_byte[0]) begin
                        res0.tx_byte = CMD_RDSR;
                        phase_next = PH_BUSY_CMD;
                    end else if (op_reg == OP_READ) begin
                        hc_next = 3'd1;
                        res0.tx_byte = CMD_READ;
                        phase_next = PH_HDR;
                    end else begin
                        res0.tx_byte = CMD_WREN;
                        res0.release_cs = 1'b1;
                        phase_next = PH_WEN;
                    end
                end
                PH_WEN:
                begin
                    res0.tx_byte = CMD_RDSR;
                    phase_next = PH_WEL_CMD;
                end
                PH_WEL_DAT:
                begin
                    if (item.rx_byte[1:0] != 2'b10) begin
                        res0.tx_byte = CMD_RDSR;
                        phase_next = PH_WEL_CMD;
                    end else begin
                        hc_next = 3'd1;
                        res0.tx_byte = wop;
                        res0.release_cs = (op_reg == OP_CE);
                        phase_next = PH_HDR;
                    end
                end
                PH_HDR:
                begin
                    if (op_reg == OP_CE) begin
                        res0.tx_byte = CMD_RDSR;
                        phase_next = PH_POST_CMD;
                    end else if (hc_reg < 3'd4) begin
                        hc_next = hc_reg + 3'd1;
                        unique case (hc_reg)
                            3'd1:    res0.tx_byte = caddr[23:16];
                            3'd2:    res0.tx_byte = caddr[15:8];
                            default: res0.tx_byte = caddr[7:0];
                        endcase
                        res0.release_cs = erase && (hc_reg == 3'd3);
                    end else if (erase) begin
                        res0.tx_byte = CMD_RDSR;
                        phase_next = PH_POST_CMD;
                    end else if (op_reg == OP_READ) begin
                        res0.tx_byte = BYTE_DUMMY;
                        res0.release_cs = (br_reg == ADDR_W'(1));
                        phase_next = PH_DATA;
                    end else begin
                        res0.tx_byte = item.wr_byte;
                        res0.release_cs = (pr_reg == (PG_LOG+1)'(1));
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    br_next = br_dec;
                    if (op_reg == OP_READ) begin
                        res0.out_kind = K_READ;
                        res0.value = {8'd0, item.rx_byte};
                        res_cnt = 2'd2;
                        if (br_dec == '0) begin
                            res1.out_kind = K_DONE;
                            phase_next = PH_IDLE;
                        end else begin
                            res1.out_kind = K_XFER;
                            res1.tx_byte = BYTE_DUMMY;
                            res1.release_cs = (br_dec == ADDR_W'(1));
                        end
                    end else begin
                        pr_next = pr_dec;
                        ap_next = ap_reg + ADDR_W'(1);
                        if (pr_dec == '0) begin
                            res0.tx_byte = CMD_RDSR;
                            phase_next = PH_POST_CMD;
                        end else begin
                            res0.tx_byte = item.wr_byte;
                            res0.release_cs = (pr_dec == (PG_LOG+1)'(1));
                        end
                    end
                end
                PH_POST_DAT:
                begin
                    if (item.rx_byte[0]) begin
                        res0.tx_byte = CMD_RDSR;
                        phase_next = PH_POST_CMD;
                    end else if (op_reg == OP_PROG && br_reg != '0) begin
                        pr_next = chunk;
                        res0.tx_byte = CMD_RDSR;
                        phase_next = PH_BUSY_CMD;
                    end else if (op_reg == OP_RANGE && ap_reg < {{SC_LOG{1'b0}}, es_reg}) begin
                        ap_next = ap_reg + ADDR_W'(1);
                        res0.tx_byte = CMD_RDSR;
                        phase_next = PH_BUSY_CMD;
                    end else begin
                        res0.out_kind = K_DONE;
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    res_cnt = 2'd0;
                    res0 = '0;
                    phase_next = PH_IDLE;
                end
            endcase
        end

        if (res_cnt == 2'd1)
            res0.last = 1'b1;
        if (res_cnt == 2'd2)
            res1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            op_reg    <= '0;
            ap_reg    <= '0;
            br_reg    <= '0;
            pr_reg    <= '0;
            hc_reg    <= '0;
            idh_reg   <= '0;
            es_reg    <= '0;
        end else if (go) begin
            phase_reg <= phase_next;
            op_reg    <= op_next;
            ap_reg    <= ap_next;
            br_reg    <= br_next;
            pr_reg    <= pr_next;
            hc_reg    <= hc_next;
            idh_reg   <= idh_next;
            es_reg    <= es_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/snfcs_rfifo.sv
// Four-entry result queue taking up to two results per cycle.
`timescale 1ns / 1ps
`default_nettype none
module snfcs_rfifo (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  wire [1:0]           push_cnt,
    input  snfcs_pkg::rsp_t     push0,
    input  snfcs_pkg::rsp_t     push1,
    output logic                room2,
    output logic                valid,
    input  wire                 stall,
    output snfcs_pkg::rsp_t     data
);
    import snfcs_pkg::*;

    rsp_t       mem_reg [4];
    logic [1:0] wp_reg, wp_next;
    logic [1:0] rp_reg, rp_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;
    logic [1:0] n_in;

    always_comb
    begin
        n_in     = push ? push_cnt : 2'd0;
        pop      = valid && !stall;
        wp_next  = wp_reg + n_in;
        rp_next  = rp_reg + {1'b0, pop};
        cnt_next = cnt_reg + {1'b0, n_in} - {2'b0, pop};
        room2    = (cnt_reg <= 3'd2);
        valid    = (cnt_reg != 3'd0);
        data     = mem_reg[rp_reg];
    end

    always_ff @(posedge clk)
    begin
        if (n_in != 2'd0)
            mem_reg[wp_reg] <= push0;
        if (n_in == 2'd2)
            mem_reg[wp_reg + 2'd1] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/spi_nor_flash_command_sequencer.sv
// Top level of the SPI NOR flash command sequencer.
//
//  channel | signals                | payload
//  --------+------------------------+---------------------------------
//  req     | req_valid / req_stall  | command or finished SPI transfer
//  rsp     | rsp_valid / rsp_stall  | SPI transfer, data, status, ID, done, reject
//
// One request is taken per cycle while req_stall is low; it is held in the input
// register, then the sequencer step writes one or two results into a 4-entry queue.
// The step waits while the queue holds more than two results; sustained rate
// is one request per cycle when each yields one result and rsp_stall stays low.
// Asynchronous active-low reset returns the sequencer to idle, queue empty.
`timescale 1ns / 1ps
`default_nettype none
module spi_nor_flash_command_sequencer #(
    parameter int PAGE_BYTES   = snfcs_pkg::DEF_PAGE_BYTES,
    parameter int SECTOR_BYTES = snfcs_pkg::DEF_SECTOR_BYTES
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_stall,
    input  snfcs_pkg::req_t     req,
    output logic                rsp_valid,
    input  wire                 rsp_stall,
    output snfcs_pkg::rsp_t     rsp
);
    import snfcs_pkg::*;

    req_t       in_reg;
    logic       in_vld_reg, in_vld_next;
    logic       room2;
    logic       go;
    logic       take;
    rsp_t       res0, res1;
    logic [1:0] res_cnt;

    always_comb
    begin
        go          = in_vld_reg && room2;
        req_stall   = in_vld_reg && !room2;
        take        = req_valid && !req_stall;
        in_vld_next = take || (in_vld_reg && !go);
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_reg <= req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    snfcs_core #(
        .PAGE_BYTES   (PAGE_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .item    (in_reg),
        .res0    (res0),
        .res1    (res1),
        .res_cnt (res_cnt)
    );

    snfcs_rfifo u_rfifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (go),
        .push_cnt (res_cnt),
        .push0    (res0),
        .push1    (res1),
        .room2    (room2),
        .valid    (rsp_valid),
        .stall    (rsp_stall),
        .data     (rsp)
    );

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the SPI NOR flash command sequencer.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import snfcs_pkg::*;

    localparam int PAGE_SZ   = DEF_PAGE_BYTES;
    localparam int SECTOR_SZ = DEF_SECTOR_BYTES;
    localparam int WATCHDOG  = 20000;

    class flash_scoreboard;
        logic [4:0]  phase;
        logic [2:0]  cur_op;
        logic [23:0] addr_ptr;
        logic [23:0] bytes_left;
        logic [8:0]  page_left;
        logic [2:0]  hdr_cnt;
        logic [7:0]  id_hi;
        logic [11:0] end_sec;
        rsp_t        pending[$];
        int          errors;
        int          checked;

        function new();
            phase = PH_IDLE; cur_op = 0; addr_ptr = 0; bytes_left = 0;
            page_left = 0; hdr_cnt = 0; id_hi = 0; end_sec = 0;
            errors = 0; checked = 0;
        endfunction

        function void push(logic [2:0] k, logic [7:0] tx, logic rel, logic [15:0] v);
            rsp_t r;
            r.out_kind = k; r.tx_byte = tx; r.release_cs = rel; r.value = v; r.last = 1'b0;
            pending.push_back(r);
        endfunction

        function void shift_out(logic [7:0] tx, logic rel, logic [4:0] nxt);
            push(K_XFER, tx, rel, 16'd0);
            phase = nxt;
        endfunction

        function void wrap_up();
            push(K_DONE, 8'd0, 1'b0, 16'd0);
            phase = PH_IDLE;
        endfunction

        function logic [8:0] page_chunk();
            int room;
            room = PAGE_SZ - (addr_ptr % PAGE_SZ);
            return 9'((room < bytes_left) ? room : bytes_left);
        endfunction

        function logic [23:0] hdr_address();
            logic [35:0] a;
            if (cur_op == OP_RANGE)
            begin
                a = addr_ptr * SECTOR_SZ;
                return a[23:0];
            end
            return addr_ptr;
        endfunction

        function logic [7:0] array_opcode();
            case (cur_op)
                OP_PROG: return CMD_PP;
                OP_BE:   return CMD_BE;
                OP_CE:   return CMD_CE;
                default: return CMD_SE;
            endcase
        endfunction

        function void start_cmd(logic [2:0] op, logic [23:0] a, logic [23:0] n);
            logic [23:0] max_sec;
            max_sec = 24'(24'hFFFFFF / SECTOR_SZ);
            if ((op == OP_READ || op == OP_PROG) && n == 0)
            begin
                push(K_REJ, 8'd0, 1'b0, 16'd0);
                return;
            end
            cur_op = op;
            case (op)
                OP_STATUS: shift_out(CMD_RDSR, 1'b0, PH_STAT_CMD);
                OP_ID:
                begin
                    hdr_cnt = 1;
                    shift_out(CMD_RDID, 1'b0, PH_ID_HDR);
                end
                OP_RANGE:
                begin
                    end_sec = 12'((n < max_sec) ? n : max_sec);
                    if (a > end_sec)
                        wrap_up();
                    else
                    begin
                        addr_ptr = a;
                        shift_out(CMD_RDSR, 1'b0, PH_BUSY_CMD);
                    end
                end
                default:
                begin
                    addr_ptr = a;
                    bytes_left = n;
                    if (op == OP_PROG)
                        page_left = page_chunk();
                    shift_out(CMD_RDSR, 1'b0, PH_BUSY_CMD);
                end
            endcase
        endfunction

        function void step_xfer(logic [7:0] rx, logic [7:0] wr);
            logic       erase;
            logic [4:0] sh;
            erase = cur_op >= OP_SE;
            case (phase)
                PH_STAT_CMD: shift_out(BYTE_DUMMY, 1'b1, PH_STAT_DAT);
                PH_STAT_DAT:
                begin
                    push(K_STAT, 8'd0, 1'b0, {8'd0, rx});
                    wrap_up();
                end
                PH_ID_HDR:
                    if (hdr_cnt < 4)
                    begin
                        hdr_cnt++;
                        shift_out(BYTE_ZERO, 1'b0, PH_ID_HDR);
                    end
                    else
                        shift_out(BYTE_DUMMY, 1'b0, PH_ID_HI);
                PH_ID_HI:
                begin
                    id_hi = rx;
                    shift_out(BYTE_DUMMY, 1'b1, PH_ID_LO);
                end
                PH_ID_LO:
                begin
                    push(K_ID, 8'd0, 1'b0, {id_hi, rx});
                    wrap_up();
                end
                PH_BUSY_CMD: shift_out(BYTE_DUMMY, 1'b1, PH_BUSY_DAT);
                PH_BUSY_DAT:
                    if (rx[0])
                        shift_out(CMD_RDSR, 1'b0, PH_BUSY_CMD);
                    else if (cur_op == OP_READ)
                    begin
                        hdr_cnt = 1;
                        shift_out(CMD_READ, 1'b0, PH_HDR);
                    end
                    else
                        shift_out(CMD_WREN, 1'b1, PH_WEN);
                PH_WEN: shift_out(CMD_RDSR, 1'b0, PH_WEL_CMD);
                PH_WEL_CMD: shift_out(BYTE_DUMMY, 1'b1, PH_WEL_DAT);
                PH_WEL_DAT:
                    if (rx[1:0] != 2'b10)
                        shift_out(CMD_RDSR, 1'b0, PH_WEL_CMD);
                    else
                    begin
                        hdr_cnt = 1;
                        shift_out(array_opcode(), cur_op == OP_CE, PH_HDR);
                    end
                PH_HDR:
                    if (cur_op == OP_CE)
                        shift_out(CMD_RDSR, 1'b0, PH_POST_CMD);
                    else if (hdr_cnt < 4)
                    begin
                        sh = 5'(8 * (3 - hdr_cnt));
                        hdr_cnt++;
                        shift_out(8'(hdr_address() >> sh), erase && hdr_cnt == 4, PH_HDR);
                    end
                    else if (erase)
                        shift_out(CMD_RDSR, 1'b0, PH_POST_CMD);
                    else if (cur_op == OP_READ)
                        shift_out(BYTE_DUMMY, bytes_left == 1, PH_DATA);
                    else
                        shift_out(wr, page_left == 1, PH_DATA);
                PH_DATA:
                    if (cur_op == OP_READ)
                    begin
                        push(K_READ, 8'd0, 1'b0, {8'd0, rx});
                        bytes_left--;
                        if (bytes_left == 0)
                            wrap_up();
                        else
                            shift_out(BYTE_DUMMY, bytes_left == 1, PH_DATA);
                    end
                    else
                    begin
                        page_left--;
                        bytes_left--;
                        addr_ptr++;
                        if (page_left == 0)
                            shift_out(CMD_RDSR, 1'b0, PH_POST_CMD);
                        else
                            shift_out(wr, page_left == 1, PH_DATA);
                    end
                PH_POST_CMD: shift_out(BYTE_DUMMY, 1'b1, PH_POST_DAT);
                PH_POST_DAT:
                    if (rx[0])
                        shift_out(CMD_RDSR, 1'b0, PH_POST_CMD);
                    else if (cur_op == OP_PROG && bytes_left != 0)
                    begin
                        page_left = page_chunk();
                        shift_out(CMD_RDSR, 1'b0, PH_BUSY_CMD);
                    end
                    else if (cur_op == OP_RANGE && addr_ptr < end_sec)
                    begin
                        addr_ptr++;
                        shift_out(CMD_RDSR, 1'b0, PH_BUSY_CMD);
                    end
                    else
                        wrap_up();
                default: phase = PH_IDLE;
            endcase
        endfunction

        function void note_request(req_t q);
            int n0;
            n0 = pending.size();
            if (q.kind == KIND_START)
            begin
                if (phase != PH_IDLE)
                    push(K_REJ, 8'd0, 1'b0, 16'd0);
                else
                    start_cmd(q.op, q.address, q.length);
            end
            else if (phase != PH_IDLE)
                step_xfer(q.rx_byte, q.wr_byte);
            if (pending.size() > n0)
                pending[pending.size() - 1].last = 1'b1;
        endfunction

        function void check_result(rsp_t got);
            rsp_t exp;
            if (pending.size() == 0)
            begin
                $error("unexpected result %p", got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (got.out_kind !== exp.out_kind)
            begin
                $error("out_kind exp %0d got %0d", exp.out_kind, got.out_kind);
                errors++;
            end
            if (got.tx_byte !== exp.tx_byte)
            begin
                $error("tx_byte exp %h got %h", exp.tx_byte, got.tx_byte);
                errors++;
            end
            if (got.release_cs !== exp.release_cs)
            begin
                $error("release_cs exp %0d got %0d", exp.release_cs, got.release_cs);
                errors++;
            end
            if (got.value !== exp.value)
            begin
                $error("value exp %h got %h", exp.value, got.value);
                errors++;
            end
            if (got.last !== exp.last)
            begin
                $error("last exp %0d got %0d", exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    flash_scoreboard sb = new();
    int idle_cycles = 0;
    int sent = 0;

    always #2 clk = ~clk;

    spi_nor_flash_command_sequencer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(rsp);
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // random receiver stall before each result; no stall while 60 < sent < 100
    initial
    begin
        int w;
        wait (rst_n);
        forever
        begin
            w = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 3);
            if (sent > 60 && sent < 100)
                w = 0;
            repeat (w)
            begin
                @(posedge clk);
                rsp_stall <= 1'b1;
            end
            @(posedge clk);
            rsp_stall <= 1'b0;
            while (!(rsp_valid && !rsp_stall))
                @(posedge clk);
        end
    end

    task automatic send(req_t q);
        int w;
        w = (sent > 60 && sent < 100) ? 0 : $urandom_range(0, 3);
        if (w > 0)
        begin
            req_valid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        req <= q;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(q);
        sent++;
    endtask

    task automatic command(logic [2:0] op, logic [23:0] a, logic [23:0] n);
        req_t q;
        q = '0;
        q.kind = KIND_START; q.op = op; q.address = a; q.length = n;
        q.rx_byte = 8'($urandom); q.wr_byte = 8'($urandom);
        send(q);
    endtask

    // finished transfer; status bytes biased so polls usually pass
    task automatic finished(int busy_pct);
        req_t q;
        q = '0;
        q.kind = 1'b1;
        q.op = 3'($urandom); q.address = 24'($urandom); q.length = 24'($urandom);
        q.wr_byte = 8'($urandom);
        q.rx_byte = 8'($urandom);
        if (sb.phase == PH_BUSY_DAT || sb.phase == PH_POST_DAT)
            q.rx_byte[0] = ($urandom_range(0, 99) < busy_pct);
        if (sb.phase == PH_WEL_DAT && $urandom_range(0, 99) >= busy_pct)
            q.rx_byte[1:0] = 2'b10;
        send(q);
    endtask

    task automatic run_to_idle(int busy_pct);
        while (sb.phase != PH_IDLE)
            finished(busy_pct);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    initial
    begin
        int k;
        logic [2:0] op;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        finished(0);
        command(OP_STATUS, 0, 0);
        finished(0); finished(0);
        command(OP_ID, 24'hFFFFFF, 24'hFFFFFF);
        command(OP_READ, 0, 0);
        run_to_idle(30);
        command(OP_READ, 24'hFFFFFF, 0);
        command(OP_PROG, 0, 0);
        command(OP_READ, 24'hFFFFFE, 2);
        run_to_idle(30);
        command(OP_PROG, 24'hFFFFFE, 4);
        run_to_idle(30);
        command(OP_SE, 24'h123456, 0);
        run_to_idle(30);
        command(OP_BE, 24'hFFFFFF, 1);
        run_to_idle(30);
        command(OP_CE, 0, 0);
        run_to_idle(30);
        command(OP_RANGE, 24'hFFF, 24'hFFFFFF);
        run_to_idle(30);
        command(OP_RANGE, 5, 4);
        command(OP_RANGE, 2, 3);
        run_to_idle(30);
        drain();

        k = 0;
        while (k < 90)
        begin
            if (sb.phase == PH_IDLE)
            begin
                if ($urandom_range(0, 9) == 0)
                    finished(30);
                else
                begin
                    op = 3'($urandom);
                    case ($urandom_range(0, 5))
                        0: command(op, 24'($urandom), 24'($urandom));
                        1: command(op, 0, 0);
                        2: command(op, 24'hFFFFFF, 24'hFFFFFF);
                        default: command(op, 24'($urandom_range(0, 40)),
                                         24'($urandom_range(1, 20)));
                    endcase
                end
            end
            else if ($urandom_range(0, 19) == 0)
                command(3'($urandom), 24'($urandom), 24'($urandom));
            else
                finished(25);
            k++;
            if (k == 45)
                drain();
        end
        drain();
        $display("Sent %0d requests, checked %0d results over all commands,", sent, sb.checked);
        $display("busy and WEL polling, page splits, rejects and range erases.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
hdl/snfcs_pkg.sv
hdl/snfcs_core.sv
hdl/snfcs_rfifo.sv
hdl/spi_nor_flash_command_sequencer.sv
tb/sv/tb_top.sv
